// File: hdl/mqed_pkg.sv
// shared types, codes and defaults for the multi-queue event dispatcher
`default_nettype none

package mqed_pkg;

  // default sizing
  localparam int NUM_ACTORS_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  // configuration port
  localparam int CFG_DATA_W = 8;
  localparam logic CFG_QUEUE_SIZE = 1'b0;
  localparam logic CFG_ENABLED    = 1'b1;

  // reset values of the configuration registers
  localparam logic [4:0] QUEUE_SIZE_RST = 5'd16;
  localparam logic [7:0] ENABLED_RST    = 8'hff;

  // input command codes
  localparam logic [1:0] CMD_POST_BACK  = 2'd0;
  localparam logic [1:0] CMD_POST_FRONT = 2'd1;
  localparam logic [1:0] CMD_SWEEP      = 2'd2;
  localparam logic [1:0] CMD_SWEEP_ALT  = 2'd3;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_DISABLED  = 3'd2,
    STAT_DELIVERED = 3'd3,
    STAT_IDLE      = 3'd4
  } status_e;

  // classified operation handed from front to engine
  typedef enum logic [1:0] {
    OP_POST_BACK,
    OP_POST_FRONT,
    OP_SWEEP,
    OP_REJECT
  } op_e;

  // engine state
  typedef enum logic {
    ENG_IDLE,
    ENG_SWEEP
  } eng_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  actor_index;
    logic [15:0] event_in;
    logic [31:0] param_in;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  actor_out;
    logic [15:0] event_out;
    logic [31:0] param_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [2:0]  actor;
    logic [15:0] evt;
    logic [31:0] par;
  } cmd_t;

endpackage

`default_nettype wire

// File: hdl/multi_queue_event_dispatcher_top.sv
// top level of the multi-queue event dispatcher
`default_nettype none

// Keeps one circular deque of (event, parameter) entries per actor slot. A post
// appends at the tail or pushes at the front and answers with one result; a
// dispatch sweep pops one entry from each enabled, non-empty slot in ascending
// order, one result per cycle while the output is not stalled, and flags the
// final one with last (an empty sweep gives one idle result). Input transactions
// pass a two-entry command queue before the engine, so the input keeps accepting
// while results wait, until that queue is full. The engine runs one command at a
// time: a sweep first takes the command and loads the slot mask, then pops the
// slots through the registered read of the single-port event memory. Result
// transactions leave from an output register.
// Configuration writes take effect at once and belong in quiet periods.

module multi_queue_event_dispatcher_top #(
  parameter int NUM_ACTORS  = mqed_pkg::NUM_ACTORS_DEF,
  parameter int QUEUE_DEPTH = mqed_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire mqed_pkg::in_item_t               in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output mqed_pkg::out_item_t                   out_item_o,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_index_i,
  input  wire logic [mqed_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mqed_pkg::*;

  logic [4:0] queue_size_q;
  logic [7:0] enabled_q;

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_size_q <= QUEUE_SIZE_RST;
      enabled_q    <= ENABLED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_QUEUE_SIZE: queue_size_q <= cfg_data_i[4:0];
        CFG_ENABLED:    enabled_q    <= cfg_data_i[7:0];
        default:        queue_size_q <= queue_size_q;
      endcase
    end
  end

  // classify incoming transactions
  mqed_front #(
    .NUM_ACTORS (NUM_ACTORS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .enabled_i   (enabled_q),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  // decouple front end from engine
  mqed_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cmd_i   (fr_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  // deques and dispatch
  mqed_engine #(
    .NUM_ACTORS  (NUM_ACTORS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_ready_o  (q_ready),
    .cmd_i        (q_cmd),
    .queue_size_i (queue_size_q),
    .enabled_i    (enabled_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire

// File: hdl/mqed_front.sv
// front end: takes input transactions and classifies them into engine commands
`default_nettype none

module mqed_front #(
  parameter int NUM_ACTORS = mqed_pkg::NUM_ACTORS_DEF
) (
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mqed_pkg::in_item_t in_item_i,
  input  wire logic [7:0]        enabled_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output mqed_pkg::cmd_t         cmd_o
);
  import mqed_pkg::*;

  localparam int NA_EFF = (NUM_ACTORS < 8) ? NUM_ACTORS : 8;

  logic usable;

  // a slot exists only below the actor count and with its enable bit set
  assign usable = (32'(in_item_i.actor_index) < 32'(NA_EFF)) &&
                  enabled_i[in_item_i.actor_index];

  // decode the command
  always_comb begin
    cmd_o.actor = in_item_i.actor_index;
    cmd_o.evt   = in_item_i.event_in;
    cmd_o.par   = in_item_i.param_in;
    unique case (in_item_i.cmd) inside
      CMD_POST_BACK:            cmd_o.op = usable ? OP_POST_BACK : OP_REJECT;
      CMD_POST_FRONT:           cmd_o.op = usable ? OP_POST_FRONT : OP_REJECT;
      CMD_SWEEP, CMD_SWEEP_ALT: cmd_o.op = OP_SWEEP;
      default:                  cmd_o.op = OP_SWEEP;
    endcase
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

`default_nettype wire

// File: hdl/mqed_cmd_fifo.sv
// two-entry command queue between front end and engine
`default_nettype none

module mqed_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire mqed_pkg::cmd_t push_cmd_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output mqed_pkg::cmd_t      pop_cmd_o
);
  import mqed_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and occupancy update
  always_comb begin
    wr_d    = push ? ~wr_q : wr_q;
    rd_d    = pop ? ~rd_q : rd_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mqed_engine.sv
// back end: per-slot deques, event memory, dispatch sweep and result register
`default_nettype none

module mqed_engine #(
  parameter int NUM_ACTORS  = mqed_pkg::NUM_ACTORS_DEF,
  parameter int QUEUE_DEPTH = mqed_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  output logic                  cmd_ready_o,
  input  wire mqed_pkg::cmd_t   cmd_i,
  input  wire logic [4:0]       queue_size_i,
  input  wire logic [7:0]       enabled_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output mqed_pkg::out_item_t   out_item_o
);
  import mqed_pkg::*;

  localparam int NA_EFF    = (NUM_ACTORS < 8) ? NUM_ACTORS : 8;
  localparam int SW        = (NA_EFF > 1) ? $clog2(NA_EFF) : 1;
  localparam int PW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int XW        = PW + 1;
  localparam int FW        = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NA_EFF * QUEUE_DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  eng_state_e  state_q, state_d;

  logic [PW-1:0] head_q [NA_EFF];
  logic [PW-1:0] head_d [NA_EFF];
  logic [PW-1:0] tail_q [NA_EFF];
  logic [PW-1:0] tail_d [NA_EFF];
  logic [FW-1:0] fill_q [NA_EFF];
  logic [FW-1:0] fill_d [NA_EFF];

  logic [NA_EFF-1:0] mask_q, mask_d;
  logic [NA_EFF-1:0] avail;
  logic [NA_EFF-1:0] rest;
  logic              rd_pend_q, rd_pend_d;
  logic [SW-1:0]     rd_slot_q, rd_slot_d;
  logic              rd_last_q, rd_last_d;

  logic [47:0]   mem_q [MEM_DEPTH];
  logic [47:0]   rd_data_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [47:0]   mem_wdata;

  out_item_t out_item_q, out_item_d;
  logic      out_valid_q;
  logic      out_load;
  logic      out_free;

  logic [FW-1:0] size_eff;
  logic [SW-1:0] slot;
  logic [SW-1:0] pick_slot;
  logic          pick_found;
  logic          issue;
  logic          can_emit;
  logic [XW-1:0] nxt;
  logic [XW-1:0] hsel;
  logic [PW-1:0] new_head;

  function automatic logic [AW-1:0] mk_addr(logic [SW-1:0] s, logic [PW-1:0] p);
    return AW'(s) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  // effective deque size: zero acts as one, clipped to the depth
  always_comb begin
    if (queue_size_i == 5'd0) begin
      size_eff = FW'(1);
    end else if (32'(queue_size_i) > 32'(QUEUE_DEPTH)) begin
      size_eff = FW'(QUEUE_DEPTH);
    end else begin
      size_eff = FW'(queue_size_i);
    end
  end

  // slots that are enabled and hold entries
  always_comb begin
    for (int i = 0; i < NA_EFF; i++) begin
      avail[i] = enabled_i[i] && (fill_q[i] != '0);
    end
  end

  // lowest pending slot of the sweep
  always_comb begin
    pick_found = 1'b0;
    pick_slot  = '0;
    for (int i = 0; i < NA_EFF; i++) begin
      if (mask_q[i] && !pick_found) begin
        pick_found = 1'b1;
        pick_slot  = SW'(i);
      end
    end
    rest            = mask_q;
    rest[pick_slot] = 1'b0;
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign can_emit = rd_pend_q && out_free;
  assign issue    = (state_q == ENG_SWEEP) && (mask_q != '0) && (!rd_pend_q || can_emit);
  assign slot     = cmd_i.actor[SW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ENG_IDLE: begin
        if (cmd_valid_i && out_free && (cmd_i.op == OP_SWEEP) && (avail != '0)) begin
          state_d = ENG_SWEEP;
        end
      end
      ENG_SWEEP: begin
        if ((mask_q == '0) && (!rd_pend_q || out_free)) begin
          state_d = ENG_IDLE;
        end
      end
      default: state_d = ENG_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    mask_d     = mask_q;
    rd_pend_d  = rd_pend_q;
    rd_slot_d  = rd_slot_q;
    rd_last_d  = rd_last_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = '0;
    mem_wdata  = {cmd_i.evt, cmd_i.par};
    out_load   = 1'b0;
    out_item_d = out_item_q;
    cmd_ready_o = 1'b0;
    nxt        = '0;
    hsel       = '0;
    new_head   = '0;
    unique case (state_q)
      ENG_IDLE: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          out_load   = 1'b1;
          out_item_d = '{status: STAT_OK, actor_out: cmd_i.actor, event_out: 16'd0,
                         param_out: 32'd0, last: 1'b1};
          unique case (cmd_i.op) inside
            OP_REJECT: begin
              out_item_d.status = STAT_DISABLED;
            end
            OP_POST_BACK, OP_POST_FRONT: begin
              if (fill_q[slot] >= size_eff) begin
                out_item_d.status = STAT_FULL;
              end else begin
                mem_we       = 1'b1;
                fill_d[slot] = fill_q[slot] + FW'(1);
                if (cmd_i.op == OP_POST_BACK) begin
                  mem_addr     = mk_addr(slot, tail_q[slot]);
                  nxt          = {1'b0, tail_q[slot]} + XW'(1);
                  tail_d[slot] = (nxt >= XW'(size_eff)) ? '0 : nxt[PW-1:0];
                end else begin
                  hsel         = (head_q[slot] == '0) ? XW'(size_eff) : {1'b0, head_q[slot]};
                  nxt          = hsel - XW'(1);
                  new_head     = nxt[PW-1:0];
                  head_d[slot] = new_head;
                  mem_addr     = mk_addr(slot, new_head);
                end
              end
            end
            OP_SWEEP: begin
              if (avail == '0) begin
                out_item_d.status    = STAT_IDLE;
                out_item_d.actor_out = 3'd0;
              end else begin
                out_load = 1'b0;
                mask_d   = avail;
              end
            end
            default: begin
              out_item_d.status = STAT_DISABLED;
            end
          endcase
        end
      end
      ENG_SWEEP: begin
        // hand the pending event read to the result register
        if (can_emit) begin
          out_load   = 1'b1;
          out_item_d = '{status: STAT_DELIVERED, actor_out: 3'(rd_slot_q),
                         event_out: rd_data_q[47:32], param_out: rd_data_q[31:0],
                         last: rd_last_q};
          rd_pend_d  = 1'b0;
        end
        // pop the head of the next pending slot
        if (issue) begin
          mem_re            = 1'b1;
          mem_addr          = mk_addr(pick_slot, head_q[pick_slot]);
          nxt               = {1'b0, head_q[pick_slot]} + XW'(1);
          head_d[pick_slot] = (nxt >= XW'(size_eff)) ? '0 : nxt[PW-1:0];
          fill_d[pick_slot] = fill_q[pick_slot] - FW'(1);
          mask_d            = rest;
          rd_pend_d         = 1'b1;
          rd_slot_d         = pick_slot;
          rd_last_d         = (rest == '0);
        end
      end
      default: begin
        cmd_ready_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ENG_IDLE;
      mask_q      <= '0;
      rd_pend_q   <= 1'b0;
      rd_slot_q   <= '0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NA_EFF; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      mask_q    <= mask_d;
      rd_pend_q <= rd_pend_d;
      rd_slot_q <= rd_slot_d;
      rd_last_q <= rd_last_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      fill_q    <= fill_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  // event memory, single port with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// File: bench/multi_queue_event_dispatcher_top_test.sv
// testbench for the multi-queue event dispatcher top level
`timescale 1ns / 1ps

module multi_queue_event_dispatcher_top_test;
  import mqed_pkg::*;

  localparam int NUM_SLOTS   = NUM_ACTORS_DEF;
  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT = 2000;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_QUEUE_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // idling odds in percent, set per phase
  int idle_pct  = 0;
  int stall_pct = 0;

  // shadow copy of the deques and registers
  logic [15:0] slot_evt [NUM_SLOTS][DEPTH] = '{default: '0};
  logic [31:0] slot_par [NUM_SLOTS][DEPTH] = '{default: '0};
  int unsigned head_pos  [NUM_SLOTS] = '{default: 0};
  int unsigned tail_pos  [NUM_SLOTS] = '{default: 0};
  int unsigned slot_fill [NUM_SLOTS] = '{default: 0};
  logic [4:0]  size_reg   = QUEUE_SIZE_RST;
  logic [7:0]  enable_reg = ENABLED_RST;

  out_item_t expected_results[$];

  // run bookkeeping
  int errors       = 0;
  int items_in     = 0;
  int results_out  = 0;
  int quiet_cycles = 0;
  int status_tally [5] = '{default: 0};

  multi_queue_event_dispatcher_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // queue size as the deques see it
  function automatic int unsigned live_size();
    if (size_reg == 5'd0) return 1;
    if (size_reg > DEPTH) return DEPTH;
    return size_reg;
  endfunction

  // work out the results of one input transaction and advance the shadow state
  function automatic void predict_dispatch(in_item_t it);
    int unsigned sz;
    int unsigned pos;
    int          a;
    int          n;
    out_item_t   r;
    sz = live_size();
    a  = it.actor_index;
    r  = '0;
    r.actor_out = it.actor_index;
    r.last      = 1'b1;
    if (it.cmd == CMD_POST_BACK || it.cmd == CMD_POST_FRONT) begin
      if (!enable_reg[a]) begin
        r.status = STAT_DISABLED;
      end else if (slot_fill[a] >= sz) begin
        r.status = STAT_FULL;
      end else begin
        if (it.cmd == CMD_POST_BACK) begin
          pos = tail_pos[a];
          tail_pos[a] = (pos + 1 >= sz) ? 0 : pos + 1;
        end else begin
          pos = (head_pos[a] == 0) ? sz - 1 : head_pos[a] - 1;
          head_pos[a] = pos;
        end
        slot_evt[a][pos] = it.event_in;
        slot_par[a][pos] = it.param_in;
        slot_fill[a]++;
        r.status = STAT_OK;
      end
      expected_results.push_back(r);
    end else begin
      // sweep: one pop per enabled non-empty slot, in slot order
      n = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (enable_reg[i] && slot_fill[i] != 0) begin
          pos = head_pos[i];
          r.status    = STAT_DELIVERED;
          r.actor_out = 3'(i);
          r.event_out = slot_evt[i][pos];
          r.param_out = slot_par[i][pos];
          r.last      = 1'b0;
          expected_results.push_back(r);
          n++;
          slot_fill[i]--;
          head_pos[i] = (pos + 1 >= sz) ? 0 : pos + 1;
        end
      end
      if (n == 0) begin
        r = '0;
        r.status = STAT_IDLE;
        r.last   = 1'b1;
        expected_results.push_back(r);
      end else begin
        r = expected_results.pop_back();
        r.last = 1'b1;
        expected_results.push_back(r);
      end
    end
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin : monitor
    out_item_t exp_r;
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_we) begin
        if (cfg_index == CFG_QUEUE_SIZE) size_reg = cfg_data[4:0];
        else enable_reg = cfg_data[7:0];
        quiet_cycles = 0;
      end
      if (in_valid && in_ready) begin
        predict_dispatch(in_item);
        items_in++;
        quiet_cycles = 0;
      end
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: status %0d actor %0d event %0h",
                 out_item.status, out_item.actor_out, out_item.event_out);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          results_out++;
          status_tally[int'(exp_r.status)]++;
          if (out_item.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_item.status);
            errors++;
          end
          if (out_item.actor_out !== exp_r.actor_out) begin
            $error("actor_out: expected %0d, got %0d", exp_r.actor_out, out_item.actor_out);
            errors++;
          end
          if (out_item.event_out !== exp_r.event_out) begin
            $error("event_out: expected %0h, got %0h", exp_r.event_out, out_item.event_out);
            errors++;
          end
          if (out_item.param_out !== exp_r.param_out) begin
            $error("param_out: expected %0h, got %0h", exp_r.param_out, out_item.param_out);
            errors++;
          end
          if (out_item.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, out_item.last);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  function automatic in_item_t pack_cmd(logic [1:0] cmd, logic [2:0] actor,
                                        logic [15:0] evt, logic [31:0] par);
    in_item_t it;
    it.cmd         = cmd;
    it.actor_index = actor;
    it.event_in    = evt;
    it.param_in    = par;
    return it;
  endfunction

  // offer one input transaction, with random idle cycles ahead of it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_sweep();
    send_item(pack_cmd(($urandom_range(9) == 0) ? CMD_SWEEP_ALT : CMD_SWEEP,
                       3'($urandom), 16'($urandom), $urandom));
  endtask

  // stop sending and let every expected result come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [4:0] size, input logic [7:0] mask);
    wait_for_drain();
    write_reg(CFG_QUEUE_SIZE, CFG_DATA_W'(size));
    write_reg(CFG_ENABLED, mask);
  endtask

  // posts at both ends, sweeps, idle sweeps and disabled slots
  task automatic t_post_and_sweep();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(pack_cmd(CMD_SWEEP, 3'd0, 16'h0, 32'h0));
    send_item(pack_cmd(CMD_POST_BACK, 3'd0, 16'h0000, 32'h0000_0000));
    send_item(pack_cmd(CMD_POST_BACK, 3'd7, 16'hffff, 32'hffff_ffff));
    send_item(pack_cmd(CMD_POST_FRONT, 3'd0, 16'h1234, 32'h89ab_cdef));
    send_item(pack_cmd(CMD_SWEEP_ALT, 3'd5, 16'hbeef, 32'h1));
    send_item(pack_cmd(CMD_SWEEP, 3'd2, 16'h0, 32'h0));
    send_item(pack_cmd(CMD_SWEEP, 3'd7, 16'h0, 32'h0));
    send_item(pack_cmd(CMD_POST_BACK, 3'd3, 16'h55aa, 32'ha5a5_a5a5));
    // slot 3 switched off while it still holds an event
    set_config(QUEUE_SIZE_RST, 8'hf7);
    send_item(pack_cmd(CMD_POST_BACK, 3'd3, 16'h0001, 32'h2));
    send_item(pack_cmd(CMD_POST_FRONT, 3'd3, 16'h0003, 32'h4));
    send_item(pack_cmd(CMD_SWEEP, 3'd0, 16'h0, 32'h0));
    set_config(QUEUE_SIZE_RST, 8'h00);
    send_item(pack_cmd(CMD_POST_BACK, 3'd5, 16'h8000, 32'h8000_0000));
    set_config(QUEUE_SIZE_RST, ENABLED_RST);
    send_item(pack_cmd(CMD_SWEEP, 3'd0, 16'h0, 32'h0));
  endtask

  // every slot to full depth and past it, then drained; leaves every entry written
  task automatic t_fill_to_depth();
    idle_pct  = 0;
    stall_pct = 0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      repeat (DEPTH + 1) begin
        send_item(pack_cmd(($urandom_range(1) == 1) ? CMD_POST_FRONT : CMD_POST_BACK,
                           3'(s), 16'($urandom), $urandom));
      end
    end
    repeat (DEPTH + 1) send_item(pack_cmd(CMD_SWEEP, 3'd0, 16'h0, 32'h0));
  endtask

  // size zero, and a deque shrunk while it still holds events
  task automatic t_size_edge_cases();
    idle_pct  = 0;
    stall_pct = 0;
    set_config(5'd0, ENABLED_RST);
    send_item(pack_cmd(CMD_POST_BACK, 3'd1, 16'h0a0a, 32'h0505_0505));
    send_item(pack_cmd(CMD_POST_FRONT, 3'd1, 16'h0b0b, 32'h0606_0606));
    send_item(pack_cmd(CMD_SWEEP, 3'd0, 16'h0, 32'h0));
    set_config(5'd16, ENABLED_RST);
    repeat (5) send_item(pack_cmd(CMD_POST_BACK, 3'd2, 16'($urandom), $urandom));
    set_config(5'd3, ENABLED_RST);
    send_item(pack_cmd(CMD_POST_FRONT, 3'd2, 16'h7777, 32'h1111_1111));
    send_item(pack_cmd(CMD_POST_BACK, 3'd2, 16'h6666, 32'h2222_2222));
    repeat (6) send_item(pack_cmd(CMD_SWEEP, 3'd0, 16'h0, 32'h0));
  endtask

  // bursts of posts to one slot, runs of sweeps, and some arbitrary commands
  task automatic t_random_traffic(input logic [4:0] size, input logic [7:0] mask,
                                  input int send_pct, input int recv_pct,
                                  input int n_items, input bit hold_off);
    int sent;
    int kind;
    int slot;
    int len;
    bit paused;
    set_config(size, mask);
    idle_pct  = send_pct;
    stall_pct = recv_pct;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      // sender holds off until the dispatcher has emptied its output
      if (hold_off && !paused && sent >= n_items / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 45) begin
        slot = $urandom_range(NUM_SLOTS - 1);
        if (mask != 8'h00) begin
          while (!mask[slot]) slot = $urandom_range(NUM_SLOTS - 1);
        end
        len = $urandom_range(18, 1);
        repeat (len) begin
          send_item(pack_cmd(($urandom_range(1) == 1) ? CMD_POST_FRONT : CMD_POST_BACK,
                             3'(slot), 16'($urandom), $urandom));
          sent++;
        end
      end else if (kind < 85) begin
        len = $urandom_range(6, 1);
        repeat (len) begin
          send_sweep();
          sent++;
        end
      end else begin
        len = $urandom_range(3, 1);
        repeat (len) begin
          send_item(pack_cmd(2'($urandom), 3'($urandom), 16'($urandom), $urandom));
          sent++;
        end
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    t_post_and_sweep();
    t_fill_to_depth();
    t_size_edge_cases();
    t_random_traffic(5'd16, 8'hff, 0, 0, 45, 1'b0);
    t_random_traffic(5'd4, 8'ha5, 71, 0, 35, 1'b1);
    t_random_traffic(5'd1, 8'h5a, 0, 71, 35, 1'b0);
    t_random_traffic(5'd31, 8'hff, 19, 19, 35, 1'b0);
    t_random_traffic(5'd7, 8'h81, 19, 19, 30, 1'b0);
    t_random_traffic(5'd0, 8'h00, 0, 0, 15, 1'b0);
    t_random_traffic(5'd17, 8'hff, 19, 19, 35, 1'b1);

    // drain, then give the dispatcher time to emit anything stray
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end

    $display("covered %0d input and %0d result transactions: %0d accepted, %0d full,",
             items_in, results_out, status_tally[STAT_OK], status_tally[STAT_FULL]);
    $display("%0d disabled, %0d delivered, %0d idle sweeps, queue sizes 0 to 31",
             status_tally[STAT_DISABLED], status_tally[STAT_DELIVERED],
             status_tally[STAT_IDLE]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mqed_pkg.sv
hdl/mqed_front.sv
hdl/mqed_cmd_fifo.sv
hdl/mqed_engine.sv
hdl/multi_queue_event_dispatcher_top.sv
bench/multi_queue_event_dispatcher_top_test.sv
